@@ rtl/rttac_pkg.sv @@
package rttac_pkg;

  localparam int MAX_SAMPLES = 65536;
  localparam int SAMPLE_W = $clog2(MAX_SAMPLES);
  localparam int CFG_IDX_W = 3;
  localparam logic signed [31:0] ONE_Q = 32'sd65536;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam int DIV_BITS = 48;

  localparam logic [CFG_IDX_W-1:0] REG_BP0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_R1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K2R  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAU  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CMAG = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PF   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UOFF = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UDUR = 3'd7;

  typedef enum logic [4:0] {
    ST_K2, ST_UPT, ST_BP, ST_DRV, ST_CP, ST_INF,
    ST_K2A, ST_DCT, ST_FS, ST_RS,
    ST_K4, ST_K3, ST_KSUM, ST_E, ST_DCF, ST_DCB, ST_FF, ST_FB, ST_RF,
    ST_ZERO
  } step_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_WB    = 5'b00100,
    S_DIV   = 5'b01000,
    S_HOLD  = 5'b10000
  } state_e;

  // bit 32 is the clamp flag
  function automatic logic [32:0] sat64(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) begin
      r = {1'b1, Q_MAX};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, Q_MIN};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

@@ rtl/reference_tissue_tac_integrator.sv @@
// channel  direction  handshake                 payload
// in       sink       in_valid_i / in_stall_o   reference_conc, reference_slope, step_length,
//                                               challenge_level, first_sample
// out      source     out_valid_o / out_stall_i tissue_conc, saturated
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
// a first sample goes from accept straight to writeback and hold; otherwise each multiply
// step runs on the one shared 32x32 multiplier and each divide on the radix-2 divider
// (skipped when the divisor is zero), with fewer steps for the one-compartment model
// than for the two-compartment model
// in_stall_o is high from accept until the result is loaded into the output register
// reset clears the state, the sample count and the output valid, and sets the config registers to their reset values
module reference_tissue_tac_integrator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [31:0]             reference_conc_i,
  input  logic signed [31:0]             reference_slope_i,
  input  logic [30:0]                    step_length_i,
  input  logic signed [31:0]             challenge_level_i,
  input  logic                           first_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [31:0]             tissue_conc_o,
  output logic                           saturated_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rttac_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import rttac_pkg::*;

  logic [30:0] bp0_q, r1_q, k2r_q, tau_q, udur_q;
  logic signed [31:0] cmag_q, pf_q, uoff_q;

  logic signed [31:0] cr_q, slope_q, chal_q;
  logic [30:0] step_q;
  logic first_q;

  logic signed [31:0] free_q, bound_q;
  logic [SAMPLE_W-1:0] idx_q;

  state_e state_q, state_d;
  step_e stp_q;

  logic signed [31:0] k2_q, bp1_q, drive_q, cp_q, inflow_q, kq_q, dct_q, k3_q, ksum_q;
  logic signed [31:0] e_q, dcf_q, dcb_q, res_q;
  logic upt_q, flag_q;

  logic signed [63:0] prod_q;
  logic signed [31:0] op_a, op_b;

  logic [31:0] rem_q, den_q;
  logic [DIV_BITS-1:0] quo_q;
  logic [5:0] dcnt_q;
  logic neg_q;

  logic out_valid_q, out_sat_q;
  logic signed [31:0] out_val_q;

  logic signed [63:0] mq_s;
  logic [32:0] mq;
  logic [32:0] trial;
  logic div_ge;
  logic out_free;
  logic signed [31:0] div_n, div_d;
  logic [32:0] den_sat;
  logic [32:0] n_abs, d_abs;
  logic [DIV_BITS-1:0] q_fin;
  logic [32:0] div_res;
  logic [32:0] s0, s1;
  logic [SAMPLE_W:0] idx_p1;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign tissue_conc_o = out_val_q;
  assign saturated_o   = out_sat_q;
  assign out_free = !out_valid_q || !out_stall_i;

  assign mq_s = (prod_q + 64'sd32768) >>> 16;
  assign mq   = sat64(mq_s);
  assign idx_p1 = {1'b0, idx_q} + {{SAMPLE_W{1'b0}}, 1'b1};

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (stp_q)
      ST_K2:   begin op_a = $signed({1'b0, r1_q});  op_b = $signed({1'b0, k2r_q}); end
      ST_UPT:  begin
        op_a = $signed(32'(idx_p1));
        op_b = $signed({1'b0, step_q});
      end
      ST_BP:   begin op_a = cmag_q;  op_b = chal_q; end
      ST_DRV:  begin op_a = $signed({1'b0, k2r_q}); op_b = cr_q; end
      ST_CP:   begin op_a = pf_q;    op_b = drive_q; end
      ST_INF:  begin op_a = $signed({1'b0, r1_q});  op_b = drive_q; end
      ST_DCT:  begin op_a = kq_q;    op_b = free_q; end
      ST_FS:   begin op_a = dct_q;   op_b = $signed({1'b0, step_q}); end
      ST_K3:   begin op_a = bp1_q;   op_b = kq_q; end
      ST_E:    begin op_a = kq_q;    op_b = bound_q; end
      ST_DCF:  begin op_a = ksum_q;  op_b = free_q; end
      ST_DCB:  begin op_a = k3_q;    op_b = free_q; end
      ST_FF:   begin op_a = dcf_q;   op_b = $signed({1'b0, step_q}); end
      ST_FB:   begin op_a = dcb_q;   op_b = $signed({1'b0, step_q}); end
      default: begin op_a = '0;      op_b = '0; end
    endcase
  end

  // divider operands
  assign den_sat = sat64(64'(ONE_Q) + 64'(bp1_q));
  always_comb begin
    if (stp_q == ST_K2A) begin
      div_n = k2_q;
      div_d = den_sat[31:0];
    end else begin
      div_n = ONE_Q;
      div_d = $signed({1'b0, tau_q});
    end
  end
  assign n_abs = div_n[31] ? 33'(-{1'b0, div_n}) : {1'b0, div_n};
  assign d_abs = div_d[31] ? 33'(-{1'b0, div_d}) : {1'b0, div_d};

  assign trial  = {rem_q, quo_q[DIV_BITS-1]};
  assign div_ge = (trial >= {1'b0, den_q});
  assign q_fin  = {quo_q[DIV_BITS-2:0], div_ge};
  always_comb begin
    if (neg_q) begin
      if (q_fin > DIV_BITS'(64'h80000000)) div_res = {1'b1, Q_MIN};
      else div_res = {1'b0, 32'(-q_fin)};
    end else begin
      if (q_fin > DIV_BITS'(64'h7fffffff)) div_res = {1'b1, Q_MAX};
      else div_res = {1'b0, q_fin[31:0]};
    end
  end

  // adder results for writeback
  always_comb begin
    s0 = '0;
    s1 = '0;
    unique case (stp_q)
      ST_BP: begin
        s0 = sat64(64'($signed({1'b0, bp0_q})) - 64'(uoff_q));
        s1 = sat64(64'($signed({1'b0, bp0_q})) - 64'($signed(mq[31:0])));
      end
      ST_DRV:  s0 = sat64(64'($signed(mq[31:0])) + 64'(slope_q));
      ST_DCT:  s0 = sat64(64'(inflow_q) - 64'($signed(mq[31:0])));
      ST_FS:   s0 = sat64(64'(free_q) + 64'($signed(mq[31:0])));
      ST_RS:   s0 = sat64(64'(free_q) + 64'(cp_q));
      ST_KSUM: s0 = sat64(64'(k2_q) + 64'(k3_q));
      ST_DCF:  s0 = sat64(64'(inflow_q) + 64'(e_q) - 64'($signed(mq[31:0])));
      ST_DCB:  s0 = sat64(64'($signed(mq[31:0])) - 64'(e_q));
      ST_FF:   s0 = sat64(64'(free_q) + 64'($signed(mq[31:0])));
      ST_FB:   s0 = sat64(64'(bound_q) + 64'($signed(mq[31:0])));
      ST_RF:   s0 = sat64(64'(free_q) + 64'(bound_q) + 64'(cp_q));
      default: s0 = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp0_q  <= 31'd65536;
      r1_q   <= 31'd65536;
      k2r_q  <= 31'd6554;
      tau_q  <= '0;
      cmag_q <= '0;
      pf_q   <= '0;
      uoff_q <= '0;
      udur_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_BP0:  bp0_q  <= cfg_data_i[30:0];
        REG_R1:   r1_q   <= cfg_data_i[30:0];
        REG_K2R:  k2r_q  <= cfg_data_i[30:0];
        REG_TAU:  tau_q  <= cfg_data_i[30:0];
        REG_CMAG: cmag_q <= $signed(cfg_data_i);
        REG_PF:   pf_q   <= $signed(cfg_data_i);
        REG_UOFF: uoff_q <= $signed(cfg_data_i);
        REG_UDUR: udur_q <= cfg_data_i[30:0];
        default:  udur_q <= udur_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stp_q       <= ST_K2;
      free_q      <= '0;
      bound_q     <= '0;
      idx_q       <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_HOLD && out_free) out_valid_q <= 1'b1;
      else if (out_free) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            flag_q <= 1'b0;
            stp_q  <= (first_sample_i || idx_q == '0) ? ST_ZERO : ST_K2;
          end
        end
        S_ISSUE: begin
          if (stp_q == ST_K2A || stp_q == ST_K4) begin
            if (div_d == '0) begin
              kq_q   <= (div_n == '0) ? '0 : (div_n[31] ? Q_MIN : Q_MAX);
              flag_q <= flag_q | (div_n != '0) | ((stp_q == ST_K2A) & den_sat[32]);
              stp_q  <= (stp_q == ST_K2A) ? ST_DCT : ST_K3;
            end else begin
              flag_q <= flag_q | ((stp_q == ST_K2A) & den_sat[32]);
              rem_q  <= '0;
              quo_q  <= {n_abs[31:0], 16'd0};
              den_q  <= d_abs[31:0];
              neg_q  <= div_n[31] ^ div_d[31];
              dcnt_q <= 6'(DIV_BITS - 1);
            end
          end
        end
        S_DIV: begin
          rem_q <= div_ge ? 32'(trial - {1'b0, den_q}) : trial[31:0];
          quo_q <= q_fin;
          dcnt_q <= dcnt_q - 6'd1;
          if (dcnt_q == '0) begin
            kq_q   <= div_res[31:0];
            flag_q <= flag_q | div_res[32];
            stp_q  <= (stp_q == ST_K2A) ? ST_DCT : ST_K3;
          end
        end
        S_WB: begin
          unique case (stp_q)
            ST_K2:  begin k2_q <= mq[31:0]; flag_q <= flag_q | mq[32]; stp_q <= ST_UPT; end
            ST_UPT: begin upt_q <= (prod_q <= 64'($signed({1'b0, udur_q}))); stp_q <= ST_BP; end
            ST_BP: begin
              if (upt_q && uoff_q != '0) begin
                bp1_q <= s0[31:0]; flag_q <= flag_q | s0[32];
              end else begin
                bp1_q <= s1[31:0]; flag_q <= flag_q | s1[32] | mq[32];
              end
              stp_q <= ST_DRV;
            end
            ST_DRV: begin drive_q <= s0[31:0]; flag_q <= flag_q | s0[32] | mq[32]; stp_q <= ST_CP; end
            ST_CP:  begin cp_q <= mq[31:0]; flag_q <= flag_q | mq[32]; stp_q <= ST_INF; end
            ST_INF: begin
              inflow_q <= mq[31:0];
              flag_q   <= flag_q | mq[32];
              stp_q    <= ($signed({1'b0, tau_q}) < ONE_Q) ? ST_K2A : ST_K4;
            end
            ST_DCT: begin dct_q <= s0[31:0]; flag_q <= flag_q | s0[32] | mq[32]; stp_q <= ST_FS; end
            ST_FS:  begin free_q <= s0[31:0]; flag_q <= flag_q | s0[32] | mq[32]; stp_q <= ST_RS; end
            ST_K3:  begin k3_q <= mq[31:0]; flag_q <= flag_q | mq[32]; stp_q <= ST_KSUM; end
            ST_KSUM: begin ksum_q <= s0[31:0]; flag_q <= flag_q | s0[32]; stp_q <= ST_E; end
            ST_E:   begin e_q <= mq[31:0]; flag_q <= flag_q | mq[32]; stp_q <= ST_DCF; end
            ST_DCF: begin dcf_q <= s0[31:0]; flag_q <= flag_q | s0[32] | mq[32]; stp_q <= ST_DCB; end
            ST_DCB: begin dcb_q <= s0[31:0]; flag_q <= flag_q | s0[32] | mq[32]; stp_q <= ST_FF; end
            ST_FF:  begin free_q <= s0[31:0]; flag_q <= flag_q | s0[32] | mq[32]; stp_q <= ST_FB; end
            ST_FB:  begin bound_q <= s0[31:0]; flag_q <= flag_q | s0[32] | mq[32]; stp_q <= ST_RF; end
            ST_RS, ST_RF: begin
              res_q  <= s0[31:0];
              flag_q <= flag_q | s0[32];
            end
            default: begin
              free_q  <= '0;
              bound_q <= '0;
              res_q   <= '0;
              flag_q  <= 1'b0;
            end
          endcase
        end
        S_HOLD: begin
          if (out_free) begin
            if (stp_q == ST_ZERO) idx_q <= SAMPLE_W'(1);
            else if (32'(idx_q) < 32'(MAX_SAMPLES - 1)) idx_q <= idx_p1[SAMPLE_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // payload, product and output registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      cr_q    <= reference_conc_i;
      slope_q <= reference_slope_i;
      step_q  <= step_length_i;
      chal_q  <= challenge_level_i;
      first_q <= first_sample_i;
    end
    if (state_q == S_ISSUE) prod_q <= op_a * op_b;
    if (state_q == S_HOLD && out_free) begin
      out_val_q <= (stp_q == ST_ZERO || first_q) && stp_q == ST_ZERO ? '0 : res_q;
      out_sat_q <= (stp_q == ST_ZERO) ? 1'b0 : flag_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = (first_sample_i || idx_q == '0) ? S_WB : S_ISSUE;
      S_ISSUE: begin
        if ((stp_q == ST_K2A || stp_q == ST_K4) && div_d != '0) state_d = S_DIV;
        else if (stp_q == ST_K2A || stp_q == ST_K4) state_d = S_ISSUE;
        else state_d = S_WB;
      end
      S_DIV:   if (dcnt_q == '0) state_d = S_ISSUE;
      S_WB: begin
        if (stp_q == ST_RS || stp_q == ST_RF || stp_q == ST_ZERO) state_d = S_HOLD;
        else state_d = S_ISSUE;
      end
      S_HOLD:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

endmodule

@@ rtl/rttac_checker.sv @@
module rttac_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic signed [31:0]              tissue_conc_o,
  input logic                            saturated_o,
  input logic                            cfg_ready_o
);

  // output item holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tissue_conc_o) && $stable(saturated_o))
    else $error("output item changed under stall");

  // an accepted item keeps the input stalled next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a new result only appears after the block was busy
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item in work");

  // the config port never blocks
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config port not ready");

endmodule

bind reference_tissue_tac_integrator rttac_checker u_rttac_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .tissue_conc_o (tissue_conc_o),
  .saturated_o   (saturated_o),
  .cfg_ready_o   (cfg_ready_o)
);
